### rtl/swfn_pkg.sv
// ----------------------------------------------------------------------------
// swfn_pkg
// Shared constants for the sliding-window first-negative block.
// ----------------------------------------------------------------------------
package swfn_pkg;

  localparam int WINDOW_SIZE_W = 7;
  localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RESET = 7'd3;

endpackage

### rtl/sliding_window_first_negative.sv
// ----------------------------------------------------------------------------
// sliding_window_first_negative
// Reports the earliest negative sample inside a sliding window of samples.
// ----------------------------------------------------------------------------
// One sample is accepted per clock cycle while in_ready is high, and its
// result, if any, appears in the output register on the next cycle; in_ready
// follows the output register (it stays high while a waiting result is being
// taken). The negative samples still inside the window are held in a
// WINDOW_MAX-entry queue memory with two registered read ports that mirror
// the queue front and the entry behind it, so each transaction does at most
// one pop and one push. A result is produced once window_size samples of the
// current array have arrived (a window_size of 0 counts as 1, one above
// WINDOW_MAX as WINDOW_MAX). After a window_size write, in_ready is held low
// while the queued entries outside the new window are popped one at a time.
module sliding_window_first_negative
  import swfn_pkg::*;
#(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [WINDOW_SIZE_W-1:0]       cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           first_of_array,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] first_negative,
  output logic                           found
);

  localparam int POS_MOD = 2 * WINDOW_MAX;
  localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int POS_W   = $clog2(POS_MOD);
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int CW      = (CNT_W > WINDOW_SIZE_W) ? CNT_W : WINDOW_SIZE_W;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(WINDOW_MAX - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [POS_W-1:0] pos_age(input logic [POS_W-1:0] p,
                                               input logic [POS_W-1:0] q);
    logic [POS_W:0] d;
    d = {1'b0, p} - {1'b0, q};
    if (p < q) d = d + (POS_W + 1)'(POS_MOD);
    return d[POS_W-1:0];
  endfunction

  // configuration
  logic [WINDOW_SIZE_W-1:0] window_size;
  logic [CW-1:0]            ws_ext;
  logic [CNT_W-1:0]         weff;

  // queue state
  logic [SAMPLE_WIDTH-1:0] mem_val [WINDOW_MAX];
  logic [POS_W-1:0]        mem_pos [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] front_val, second_val;
  logic [POS_W-1:0]        front_pos, second_pos;
  logic [PTR_W-1:0]        head, head_next, tail, tail_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [POS_W-1:0]        position, position_next;
  logic [CNT_W-1:0]        fill, fill_next;
  logic                    draining, draining_next;

  // step logic
  logic                    accept;
  logic [PTR_W-1:0]        base_head, base_tail, head_pop, rd_addr0, rd_addr1;
  logic [CNT_W-1:0]        base_cnt, cnt_pop;
  logic [POS_W-1:0]        base_pos;
  logic [CNT_W-1:0]        base_fill;
  logic                    pop, push, drain_pop;
  logic                    res_valid, res_found;
  logic [SAMPLE_WIDTH-1:0] res_val;

  assign ws_ext = CW'(window_size);
  always_comb begin
    priority if (ws_ext == '0) begin
      weff = CNT_W'(1);
    end else if (ws_ext > CW'(WINDOW_MAX)) begin
      weff = CNT_W'(WINDOW_MAX);
    end else begin
      weff = ws_ext[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  assign in_ready = !draining && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    base_head = first_of_array ? '0 : head;
    base_tail = first_of_array ? '0 : tail;
    base_cnt  = first_of_array ? '0 : count;
    base_pos  = first_of_array ? '0 : position;
    base_fill = first_of_array ? '0 : fill;

    pop      = (base_cnt != '0) && (pos_age(base_pos, front_pos) >= POS_W'(weff));
    head_pop = pop ? ptr_inc(base_head) : base_head;
    cnt_pop  = base_cnt - CNT_W'(pop);
    push     = sample[SAMPLE_WIDTH-1] && (cnt_pop < CNT_W'(WINDOW_MAX));

    res_valid = ((base_fill < weff) ? base_fill + 1'b1 : weff) == weff;
    priority if (cnt_pop != '0) begin
      res_found = 1'b1;
      res_val   = pop ? second_val : front_val;
    end else if (push) begin
      res_found = 1'b1;
      res_val   = sample;
    end else begin
      res_found = 1'b0;
      res_val   = '0;
    end

    drain_pop = (count != '0) && (pos_age(position, front_pos) >= POS_W'(weff));

    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    position_next = position;
    fill_next     = fill;
    draining_next = draining;
    if (accept) begin
      head_next     = head_pop;
      tail_next     = push ? ptr_inc(base_tail) : base_tail;
      count_next    = cnt_pop + CNT_W'(push);
      position_next = (base_pos == POS_W'(POS_MOD - 1)) ? '0 : base_pos + 1'b1;
      fill_next     = (base_fill < weff) ? base_fill + 1'b1 : weff;
    end else if (draining) begin
      if (drain_pop) begin
        head_next  = ptr_inc(head);
        count_next = count - 1'b1;
      end else begin
        draining_next = 1'b0;
      end
    end
    if (cfg_we) draining_next = 1'b1;
  end

  assign rd_addr0 = head_next;
  assign rd_addr1 = ptr_inc(head_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      position <= '0;
      fill     <= '0;
      draining <= 1'b0;
    end else begin
      head     <= head_next;
      tail     <= tail_next;
      count    <= count_next;
      position <= position_next;
      fill     <= fill_next;
      draining <= draining_next;
    end
  end

  // queue memory; read ports mirror the front and the entry behind it
  always_ff @(posedge clk) begin
    if (accept && push) begin
      mem_val[base_tail] <= sample;
      mem_pos[base_tail] <= base_pos;
    end
    if (accept && push && base_tail == rd_addr0) begin
      front_val <= sample;
      front_pos <= base_pos;
    end else begin
      front_val <= mem_val[rd_addr0];
      front_pos <= mem_pos[rd_addr0];
    end
    if (accept && push && base_tail == rd_addr1) begin
      second_val <= sample;
      second_pos <= base_pos;
    end else begin
      second_val <= mem_val[rd_addr1];
      second_pos <= mem_pos[rd_addr1];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      first_negative <= res_val;
      found          <= res_found;
    end
  end

  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> first_negative == '0)
    else $error("result without negative carries nonzero value");

  a_found_negative: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> first_negative[SAMPLE_WIDTH-1])
    else $error("reported first negative is not negative");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(WINDOW_MAX))
    else $error("queue count exceeds depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == tail)
    else $error("empty queue with unequal pointers");

  a_second_order: assert property (@(posedge clk) disable iff (rst)
    count > CNT_W'(1) |-> second_pos != front_pos)
    else $error("queue front entries share a position");

endmodule
